FILE: sv/fisa_pkg.sv
// ----------------------------------------------------------------------------
// fisa_pkg
// Shared types and constants for the free index stack allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fisa_pkg;

  // Default geometry of the index stack.
  localparam int unsigned DEPTH_DEF = 4096;
  localparam int unsigned BATCH_DEF = 512;

  // Request function codes.
  localparam logic [1:0] FUNC_POP  = 2'd0;
  localparam logic [1:0] FUNC_PUSH = 2'd1;
  localparam logic [1:0] FUNC_INIT = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RANGE_BOTTOM = 2'd0;
  localparam logic [1:0] CFG_RANGE_TOP    = 2'd1;
  localparam logic [1:0] CFG_RANGE_MAX    = 2'd2;

  // Controller sequencing states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_WAIT
  } state_t;

  // One finished result handed from the controller to the output register.
  typedef struct packed {
    logic        valid;
    logic [31:0] index_out;
    logic [1:0]  status;
  } res_t;

endpackage : fisa_pkg

`default_nettype wire

FILE: sv/free_index_stack_allocator.sv
// ----------------------------------------------------------------------------
// free_index_stack_allocator
// Allocator of 32-bit indices kept on a stack in an on-chip memory.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A push, a pop that finds the stack
// empty and exhausted, and an unused function code finish with no memory
// read or fill. A pop from a non-empty stack waits for the registered read
// data of the index memory. An init writes one stack entry per cycle after
// the cycle it is taken in, min(range_top - range_bottom, DEPTH) in all, none
// for an empty range. A pop that refills an empty stack returns the last of
// min(BATCH, DEPTH, limit - fresh) fresh indices directly and writes the rest
// one per cycle. A result waits in the output register while the next
// transaction is taken. Stack entries hold no value until written. The user must
// write configuration only while the block is idle; this is not enforced.
`default_nettype none

module free_index_stack_allocator #(
  parameter int unsigned DEPTH = fisa_pkg::DEPTH_DEF,
  parameter int unsigned BATCH = fisa_pkg::BATCH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_index_out,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  import fisa_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [31:0]   range_bottom_r;
  logic [31:0]   range_top_r;
  logic [31:0]   range_max_r;
  logic          out_valid_r;
  logic [31:0]   out_index_r;
  logic [1:0]    out_status_r;
  logic          out_free;
  res_t          res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_bottom_r <= '0;
      range_top_r    <= '0;
      range_max_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_BOTTOM: range_bottom_r <= cfg_data;
        CFG_RANGE_TOP:    range_top_r    <= cfg_data;
        CFG_RANGE_MAX:    range_max_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_index_r  <= res.index_out;
      out_status_r <= res.status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index_out = out_index_r;
  assign out_status    = out_status_r;

  // Stack controller.
  fisa_ctrl #(
    .DEPTH (DEPTH),
    .BATCH (BATCH),
    .AW    (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_index     (in_index),
    .range_bottom (range_bottom_r),
    .range_top    (range_top_r),
    .range_max    (range_max_r),
    .out_free     (out_free),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  // Index memory.
  fisa_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule : free_index_stack_allocator

`default_nettype wire

FILE: sv/fisa_store.sv
// ----------------------------------------------------------------------------
// fisa_store
// Single-port-write, single-port-read index memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fisa_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : fisa_store

`default_nettype wire

FILE: sv/fisa_ctrl.sv
// ----------------------------------------------------------------------------
// fisa_ctrl
// Stack controller: fill count, fresh pointer, fill sequencer and results.
// ----------------------------------------------------------------------------
`default_nettype none

module fisa_ctrl #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned BATCH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_func,
  input  wire logic [31:0]       in_index,
  input  wire logic [31:0]       range_bottom,
  input  wire logic [31:0]       range_top,
  input  wire logic [31:0]       range_max,
  input  wire logic              out_free,
  output fisa_pkg::res_t         res,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [31:0]            wr_data,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  wire logic [31:0]       rd_data
);

  import fisa_pkg::*;

  localparam int unsigned CW         = AW + 1;
  localparam int unsigned REFILL_MAX = (BATCH < DEPTH) ? BATCH : DEPTH;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [31:0]    fresh_r, fresh_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  end_r, end_nxt;
  logic [31:0]    val_r, val_nxt;
  logic [31:0]    res_index_r, res_index_nxt;
  logic [1:0]     res_status_r, res_status_nxt;

  logic           accept;
  logic           done;
  logic [31:0]    limit;
  logic [31:0]    avail;
  logic [CW-1:0]  refill_n;
  logic [31:0]    span;
  logic           span_over;
  logic [CW-1:0]  init_n;

  // Range arithmetic for refill and init.
  always_comb begin
    limit     = (range_max != 32'd0) ? range_max : range_top;
    avail     = limit - fresh_r;
    refill_n  = (avail > 32'(REFILL_MAX)) ? CW'(REFILL_MAX) : avail[CW-1:0];
    span      = (range_top > range_bottom) ? (range_top - range_bottom) : 32'd0;
    span_over = (span > 32'(DEPTH));
    init_n    = span_over ? CW'(DEPTH) : span[CW-1:0];
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state, memory accesses and result hand-off.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    fresh_nxt      = fresh_r;
    cnt_nxt        = cnt_r;
    end_nxt        = end_r;
    val_nxt        = val_r;
    res_index_nxt  = res_index_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_addr        = cnt_r[AW-1:0];
    wr_data        = val_r;
    rd_en          = 1'b0;
    rd_addr        = AW'(fill_r - CW'(1));
    res            = '0;
    done           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_index_nxt  = 32'd0;
          res_status_nxt = STATUS_OK;
          unique case (in_func)
            FUNC_POP: begin
              if (fill_r != CW'(0)) begin
                // Top entry comes back from memory next cycle.
                rd_en     = 1'b1;
                fill_nxt  = fill_r - CW'(1);
                state_nxt = ST_READ;
              end else if (fresh_r >= limit) begin
                res_status_nxt = STATUS_EXHAUSTED;
                done           = 1'b1;
              end else begin
                // Refill: the last fresh index is returned directly, the
                // rest are written to the stack.
                fresh_nxt     = fresh_r + 32'(refill_n);
                fill_nxt      = refill_n - CW'(1);
                res_index_nxt = fresh_r + 32'(refill_n) - 32'd1;
                cnt_nxt       = '0;
                end_nxt       = refill_n - CW'(1);
                val_nxt       = fresh_r;
                if (refill_n == CW'(1)) begin
                  done = 1'b1;
                end else begin
                  state_nxt = ST_FILL;
                end
              end
            end
            FUNC_PUSH: begin
              if (fill_r == CW'(DEPTH)) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = fill_r[AW-1:0];
                wr_data  = in_index;
                fill_nxt = fill_r + CW'(1);
              end
              done = 1'b1;
            end
            FUNC_INIT: begin
              fresh_nxt      = range_top;
              fill_nxt       = init_n;
              cnt_nxt        = '0;
              end_nxt        = init_n;
              val_nxt        = range_bottom;
              res_status_nxt = span_over ? STATUS_FULL : STATUS_OK;
              if (init_n == CW'(0)) begin
                done = 1'b1;
              end else begin
                state_nxt = ST_FILL;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_index_nxt  = rd_data;
        res_status_nxt = STATUS_OK;
        done           = 1'b1;
      end
      ST_FILL: begin
        // One stack entry written per cycle.
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        val_nxt = val_r + 32'd1;
        if (cnt_r + CW'(1) == end_r) begin
          done = 1'b1;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          res.valid     = 1'b1;
          res.index_out = res_index_r;
          res.status    = res_status_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A finished result goes to the output register or waits here.
    if (done) begin
      if (out_free) begin
        res.valid     = 1'b1;
        res.index_out = res_index_nxt;
        res.status    = res_status_nxt;
        state_nxt     = ST_IDLE;
      end else begin
        state_nxt = ST_WAIT;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // Sequencer and pending result payload.
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    end_r        <= end_nxt;
    val_r        <= val_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule : fisa_ctrl

`default_nettype wire
